@@ rtl/core/bfsa_pkg.sv @@
// ----------------------------------------------------------------------------
// Best-fit span allocator package
// Shared widths, table sizes and request and status codes.
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int unsigned PoolBytes = 1048576;
  localparam int unsigned MaxSpans  = 64;
  localparam int unsigned IdxW      = $clog2(MaxSpans);
  localparam int unsigned CntW      = $clog2(MaxSpans + 1);
  localparam int unsigned AddrW     = 20;
  localparam int unsigned SizeW     = 21;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_REALLOC = 2'd1,
    FUNC_FREE    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_NOADDR = 3'd2,
    ST_FULL   = 3'd3,
    ST_ZERO   = 3'd4
  } status_e;

endpackage

@@ rtl/core/best_fit_span_allocator.sv @@
// ----------------------------------------------------------------------------
// Best-fit span allocator
// Manages a byte pool as a free span table and an allocated span table.
// ----------------------------------------------------------------------------
// Usage: a request (func_i, req_size_i, address_i) is one transfer on the
// input channel; exactly one result (status_o, span_address_o, freed_size_o,
// free_total_o) follows on the output channel. Allocate takes the smallest
// free span that fits, the lowest start winning a tie; free returns a span
// without coalescing; reallocate allocates first, then frees the old span.
// Both tables live in synchronous RAMs with registered read data. One
// request scans all MaxSpans entries of both tables in a single pass, reading
// one entry of each per cycle, then writes back in states S_W1 and S_W2 and
// loads the output register in S_W3 once the output register is free.
// The block works on one request at a time; the next request is taken once
// the result sits in the output register, even while the receiver stalls,
// and its scan proceeds but its result waits until the output frees up.
// Reset empties the allocated table; state S_INIT then writes the
// single free span that covers the pool, and input stays blocked meanwhile.
// ----------------------------------------------------------------------------
module best_fit_span_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [20:0] req_size_i,
  input  logic [19:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [19:0] span_address_o,
  output logic [20:0] freed_size_o,
  output logic [20:0] free_total_o
);

  localparam int unsigned IW = bfsa_pkg::IdxW;
  localparam int unsigned CW = bfsa_pkg::CntW;
  localparam int unsigned AW = bfsa_pkg::AddrW;
  localparam int unsigned SW = bfsa_pkg::SizeW;
  localparam int unsigned NS = bfsa_pkg::MaxSpans;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_W1   = 7'b0001000,
    S_W2   = 7'b0010000,
    S_W3   = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  // Memories: start and size of each table.
  logic [AW-1:0] fstart_mem [NS];
  logic [SW-1:0] fsize_mem  [NS];
  logic [AW-1:0] ustart_mem [NS];
  logic [SW-1:0] usize_mem  [NS];
  logic [NS-1:0] fvalid_q, uvalid_q;

  logic [IW-1:0] rd_idx;
  logic [AW-1:0] fstart_rd, ustart_rd;
  logic [SW-1:0] fsize_rd, usize_rd;

  logic          fwe, uwe;
  logic [IW-1:0] fwa, uwa;
  logic [AW-1:0] fwstart, uwstart;
  logic [SW-1:0] fwsize, uwsize;

  always_ff @(posedge clk_i) begin
    if (fwe) begin
      fstart_mem[fwa] <= fwstart;
      fsize_mem[fwa]  <= fwsize;
    end
    if (uwe) begin
      ustart_mem[uwa] <= uwstart;
      usize_mem[uwa]  <= uwsize;
    end
    fstart_rd <= fstart_mem[rd_idx];
    fsize_rd  <= fsize_mem[rd_idx];
    ustart_rd <= ustart_mem[rd_idx];
    usize_rd  <= usize_mem[rd_idx];
  end

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    func_q;
  logic [SW-1:0] req_q;
  logic [AW-1:0] addr_q;
  logic [IW-1:0] ridx_q;
  logic          rvld_q;
  // Best fit candidate.
  logic          bf_ok_q;
  logic [IW-1:0] bf_idx_q;
  logic [AW-1:0] bf_start_q;
  logic [SW-1:0] bf_size_q;
  // Address match.
  logic          um_ok_q;
  logic [IW-1:0] um_idx_q;
  logic [AW-1:0] um_start_q;
  logic [SW-1:0] um_size_q;
  logic [SW-1:0] free_bytes_q;
  logic          ovalid_q;
  logic [2:0]    ostat_q;
  logic [AW-1:0] oaddr_q;
  logic [SW-1:0] oold_q;
  logic [SW-1:0] ofree_q;
  logic [2:0]    res_stat_q, res_stat_d;
  logic [SW-1:0] res_old_q, res_old_d;

  // Lowest free slots, taken from flip-flop valid bits.
  logic          fo_ok, uo_ok, fo2_ok;
  logic [IW-1:0] fo_idx, uo_idx, fo2_idx;
  logic [NS-1:0] fvalid_after;

  always_comb begin
    fo_ok = 1'b0; fo_idx = '0;
    uo_ok = 1'b0; uo_idx = '0;
    for (int k = NS - 1; k >= 0; k--) begin
      if (!fvalid_q[k]) begin fo_ok = 1'b1; fo_idx = IW'(k); end
      if (!uvalid_q[k]) begin uo_ok = 1'b1; uo_idx = IW'(k); end
    end
  end

  // Free table valid bits after the allocation half of a reallocate.
  always_comb begin
    fvalid_after = fvalid_q;
    if (bf_size_q == req_q) fvalid_after[bf_idx_q] = 1'b0;
    fo2_ok = 1'b0; fo2_idx = '0;
    for (int k = NS - 1; k >= 0; k--) begin
      if (!fvalid_after[k]) begin fo2_ok = 1'b1; fo2_idx = IW'(k); end
    end
  end

  logic in_fire, out_fire, out_free;
  assign out_fire   = ovalid_q && out_ready_i;
  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign rd_idx     = cnt_q[IW-1:0];

  logic is_alloc, is_realloc, is_free, exact;
  assign is_alloc   = (func_q == bfsa_pkg::FUNC_ALLOC) || (func_q == bfsa_pkg::FUNC_REALLOC);
  assign is_realloc = (func_q == bfsa_pkg::FUNC_REALLOC);
  assign is_free    = (func_q == bfsa_pkg::FUNC_FREE);
  assign exact      = (bf_size_q == req_q);

  // Decision, made once the scan is complete.
  always_comb begin
    res_stat_d = bfsa_pkg::ST_OK;
    res_old_d  = '0;
    if (is_alloc) begin
      if (is_realloc && !um_ok_q)                    res_stat_d = bfsa_pkg::ST_NOADDR;
      else if (req_q == '0)                          res_stat_d = bfsa_pkg::ST_ZERO;
      else if (!bf_ok_q)                             res_stat_d = bfsa_pkg::ST_NOFIT;
      else if (!uo_ok)                               res_stat_d = bfsa_pkg::ST_FULL;
      else if (is_realloc && !exact && !fo_ok)       res_stat_d = bfsa_pkg::ST_FULL;
      if (is_realloc) res_old_d = um_size_q;
    end else if (is_free) begin
      if (!um_ok_q)     res_stat_d = bfsa_pkg::ST_NOADDR;
      else if (!fo_ok)  res_stat_d = bfsa_pkg::ST_FULL;
      res_old_d = um_size_q;
    end
  end

  logic scan_end, ok_q;
  assign scan_end = (state_q == S_SCAN) && !rvld_q && (cnt_q == CW'(NS)) ;
  assign ok_q     = (res_stat_q == bfsa_pkg::ST_OK);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fwe = 1'b0; fwa = '0; fwstart = '0; fwsize = '0;
    uwe = 1'b0; uwa = uo_idx; uwstart = bf_start_q; uwsize = req_q;
    case (state_q)
      S_INIT: begin
        // The one free span that covers the whole pool.
        fwe     = 1'b1;
        fwsize  = SW'(bfsa_pkg::PoolBytes);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        cnt_d = '0;
        if (in_fire) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_q != CW'(NS)) cnt_d = cnt_q + CW'(1);
        if (scan_end) state_d = S_W1;
      end
      S_W1: begin
        // Allocation write: used entry and the trimmed free entry.
        if (ok_q && is_alloc) begin
          uwe = 1'b1;
          if (!exact) begin
            fwe = 1'b1; fwa = bf_idx_q;
            fwstart = bf_start_q + AW'(req_q);
            fwsize  = bf_size_q - req_q;
          end
        end
        state_d = S_W2;
      end
      S_W2: begin
        // Release write into the lowest open free slot.
        if (ok_q && (is_realloc || is_free)) begin
          fwe = 1'b1;
          fwa = is_realloc ? fo2_idx : fo_idx;
          fwstart = um_start_q; fwsize = um_size_q;
        end
        state_d = S_W3;
      end
      S_W3: begin
        if (out_free) state_d = S_DONE;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cnt_q        <= '0;
      rvld_q       <= 1'b0;
      fvalid_q     <= NS'(1);
      uvalid_q     <= '0;
      free_bytes_q <= SW'(bfsa_pkg::PoolBytes);
      ovalid_q     <= 1'b0;
      ofree_q      <= SW'(bfsa_pkg::PoolBytes);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rvld_q  <= (state_q == S_SCAN) && (cnt_q != CW'(NS));
      if (state_q == S_W1 && ok_q && is_alloc) begin
        uvalid_q[uo_idx] <= 1'b1;
        if (exact) fvalid_q[bf_idx_q] <= 1'b0;
        free_bytes_q <= free_bytes_q - req_q;
      end
      if (state_q == S_W2 && ok_q && (is_realloc || is_free)) begin
        fvalid_q[fwa]      <= 1'b1;
        uvalid_q[um_idx_q] <= 1'b0;
        free_bytes_q       <= free_bytes_q + um_size_q;
      end
      if (state_q == S_W3 && out_free) begin
        ovalid_q <= 1'b1;
        ofree_q  <= free_bytes_q;
      end else if (out_fire) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Scan datapath and payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q   <= func_i;
      req_q    <= req_size_i;
      addr_q   <= address_i;
      bf_ok_q  <= 1'b0;
      um_ok_q  <= 1'b0;
      bf_idx_q <= '0;
      bf_start_q <= '0;
      bf_size_q  <= '0;
      um_idx_q   <= '0;
      um_start_q <= '0;
      um_size_q  <= '0;
    end
    ridx_q <= rd_idx;
    if (rvld_q) begin
      if (fvalid_q[ridx_q] && fsize_rd >= req_q &&
          (!bf_ok_q || fsize_rd < bf_size_q ||
           (fsize_rd == bf_size_q && fstart_rd < bf_start_q))) begin
        bf_ok_q    <= 1'b1;
        bf_idx_q   <= ridx_q;
        bf_start_q <= fstart_rd;
        bf_size_q  <= fsize_rd;
      end
      if (!um_ok_q && uvalid_q[ridx_q] && ustart_rd == addr_q) begin
        um_ok_q    <= 1'b1;
        um_idx_q   <= ridx_q;
        um_start_q <= ustart_rd;
        um_size_q  <= usize_rd;
      end
    end
    if (scan_end) begin
      res_stat_q <= res_stat_d;
      res_old_q  <= res_old_d;
    end
    if (state_q == S_W3 && out_free) begin
      ostat_q <= res_stat_q;
      oaddr_q <= (ok_q && is_alloc) ? bf_start_q : '0;
      oold_q  <= (ok_q && (is_realloc || is_free)) ? res_old_q : '0;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign status_o       = ostat_q;
  assign span_address_o = oaddr_q;
  assign freed_size_o   = oold_q;
  assign free_total_o   = ofree_q;

endmodule

@@ rtl/core/bfsa_checker.sv @@
// ----------------------------------------------------------------------------
// Best-fit span allocator checker
// Port-level properties of the allocator, attached by bind.
// ----------------------------------------------------------------------------
module bfsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [19:0] span_address_o,
  input logic [20:0] freed_size_o,
  input logic [20:0] free_total_o
);

  // A stalled result holds its status and span address.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(span_address_o))
    else $error("stalled result changed");

  // The free total never exceeds the pool.
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_o <= 21'(bfsa_pkg::PoolBytes))
    else $error("free total above pool size");

  // A refused request reports no span and no released size.
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != 3'(bfsa_pkg::ST_OK) |->
    span_address_o == '0 && freed_size_o == '0)
    else $error("failed request carries data");

  // A request accepted leaves the block busy in the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transfer taken during scan");

endmodule

bind best_fit_span_allocator bfsa_checker u_bfsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .span_address_o(span_address_o),
  .freed_size_o  (freed_size_o),
  .free_total_o  (free_total_o)
);
